// ===== src/sha1_pkg.sv =====
// sha1 package: item types, constants and round helpers
`timescale 1ns / 1ps
package sha1_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // front to back command
  typedef struct packed {
    logic [31:0] word;
    logic [3:0]  widx;
    logic        is_word;   // store word at widx
    logic        compress;  // run compression after store
    logic        finish;    // emit digest and reinit after compression
  } cmd_t;

  localparam int LengthBitsDefault = 32;
  localparam int unsigned DigestWords = 5;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [7:0]  PadByte = 8'h80;

  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] k;
    if (r < 7'd20) k = 32'h5A827999;
    else if (r < 7'd40) k = 32'h6ED9EBA1;
    else if (r < 7'd60) k = 32'h8F1BBCDC;
    else k = 32'hCA62C1D6;
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (r < 7'd20) f = (b & c) | (~b & d);
    else if (r >= 7'd40 && r < 7'd60) f = (b & c) | (b & d) | (c & d);
    else f = b ^ c ^ d;
    return f;
  endfunction

endpackage

// ===== src/sha1_front.sv =====
// sha1 front: packs bytes into words, counts length, emits padding commands
`timescale 1ns / 1ps
module sha1_front #(
  parameter int LengthBits = sha1_pkg::LengthBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sha1_pkg::in_item_t in_item_i,
  output logic              full_o,
  output logic              cmd_valid_o,
  output sha1_pkg::cmd_t    cmd_o,
  input  logic              cmd_ready_i
);
  import sha1_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPadW = 3'd1;  // flush partial word with pad byte
  localparam logic [2:0] StZero = 3'd2;  // zero words up to index 13
  localparam logic [2:0] StLenH = 3'd3;
  localparam logic [2:0] StLenL = 3'd4;

  localparam logic [LengthBits-1:0] CountMax = '1;

  logic [2:0]            state_q, state_d;
  logic [23:0]           acc_q, acc_d;
  logic [5:0]            fill_q, fill_d;
  logic [LengthBits-1:0] count_q, count_d;
  logic [3:0]            zidx_q, zidx_d;
  logic [63:0]           bits;
  logic [31:0]           word;
  logic                  take;

  assign full_o = (state_q != StIdle) || !cmd_ready_i;
  assign take   = push_i && !full_o;
  assign bits   = {{(64-LengthBits){1'b0}}, count_q} << 3;

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    fill_d      = fill_q;
    count_d     = count_q;
    zidx_d      = zidx_q;
    cmd_valid_o = 1'b0;
    cmd_o       = '0;
    word        = '0;
    unique case (state_q)
      StIdle: begin
        if (take) begin
          if (in_item_i.has_data) begin
            count_d = (count_q == CountMax) ? count_q : count_q + 1'b1;
            fill_d  = fill_q + 6'd1;
            acc_d   = {acc_q[15:0], in_item_i.data_byte};
            if (fill_q[1:0] == 2'd3) begin
              cmd_valid_o  = 1'b1;
              cmd_o.word   = {acc_q, in_item_i.data_byte};
              cmd_o.widx   = fill_q[5:2];
              cmd_o.is_word  = 1'b1;
              cmd_o.compress = (fill_q == 6'd63);
            end
          end
          if (in_item_i.last_byte) begin
            state_d = StPadW;
          end
        end
      end
      StPadW: begin
        unique case (fill_q[1:0])
          2'd0: word = {PadByte, 24'd0};
          2'd1: word = {acc_q[7:0], PadByte, 16'd0};
          2'd2: word = {acc_q[15:0], PadByte, 8'd0};
          default: word = {acc_q, PadByte};
        endcase
        cmd_valid_o    = 1'b1;
        cmd_o.word     = word;
        cmd_o.widx     = fill_q[5:2];
        cmd_o.is_word  = 1'b1;
        cmd_o.compress = (fill_q >= 6'd56);
        if (cmd_ready_i) begin
          zidx_d  = fill_q[5:2] + 4'd1;
          state_d = (fill_q >= 6'd56) ? StZero : ((fill_q[5:2] == 4'd13) ? StLenH : StZero);
          if (fill_q >= 6'd56) zidx_d = 4'd0;
          if (fill_q >= 6'd56 || fill_q[5:2] != 4'd13) begin
            if (fill_q < 6'd56 && fill_q[5:2] + 4'd1 == 4'd14) state_d = StLenH;
          end
        end
      end
      StZero: begin
        cmd_valid_o   = 1'b1;
        cmd_o.widx    = zidx_q;
        cmd_o.is_word = 1'b1;
        if (cmd_ready_i) begin
          zidx_d = zidx_q + 4'd1;
          if (zidx_q == 4'd13) state_d = StLenH;
        end
      end
      StLenH: begin
        cmd_valid_o   = 1'b1;
        cmd_o.word    = bits[63:32];
        cmd_o.widx    = 4'd14;
        cmd_o.is_word = 1'b1;
        if (cmd_ready_i) state_d = StLenL;
      end
      StLenL: begin
        cmd_valid_o    = 1'b1;
        cmd_o.word     = bits[31:0];
        cmd_o.widx     = 4'd15;
        cmd_o.is_word  = 1'b1;
        cmd_o.compress = 1'b1;
        cmd_o.finish   = 1'b1;
        if (cmd_ready_i) begin
          state_d = StIdle;
          count_d = '0;
          fill_d  = '0;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fill_q      <= '0;
      count_q     <= '0;
      zidx_q      <= '0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      count_q     <= count_d;
      zidx_q      <= zidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
  end

endmodule

// ===== src/sha1_cmd_fifo.sv =====
// sha1 command queue between front and back
`timescale 1ns / 1ps
module sha1_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  input  sha1_pkg::cmd_t wr_cmd_i,
  output logic           wr_ready_o,
  output logic           rd_valid_o,
  output sha1_pkg::cmd_t rd_cmd_o,
  input  logic           rd_ready_i
);
  import sha1_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_cmd_o   = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// ===== src/sha1_core.sv =====
// sha1 back end: block store, 80-round compression, digest output
`timescale 1ns / 1ps
module sha1_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  sha1_pkg::cmd_t        cmd_i,
  output logic                  cmd_ready_o,
  output logic                  empty_o,
  output sha1_pkg::out_item_t   out_item_o,
  input  logic                  pop_i
);
  import sha1_pkg::*;

  localparam logic [1:0] StLoad = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StAdd  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0]  state_q;
  logic [31:0] w_q [16];
  logic [31:0] h_q [5];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [6:0]  r_q;
  logic        fin_q;
  logic [2:0]  oidx_q;
  logic [31:0] wr_word, t;
  logic [3:0]  ri;

  assign ri          = r_q[3:0];
  assign cmd_ready_o = (state_q == StLoad);
  assign empty_o     = (state_q != StOut);
  assign out_item_o.digest_word = h_q[oidx_q];
  assign out_item_o.word_index  = oidx_q;
  assign out_item_o.last_word   = (oidx_q == 3'd4);

  always_comb begin
    if (r_q < 7'd16) wr_word = w_q[ri];
    else begin
      wr_word = w_q[ri - 4'd3] ^ w_q[ri - 4'd8] ^ w_q[ri - 4'd14] ^ w_q[ri];
      wr_word = {wr_word[30:0], wr_word[31]};
    end
    t = {a_q[26:0], a_q[31:27]} + round_f(r_q, b_q, c_q, d_q) + e_q + round_k(r_q) + wr_word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) w_q[i] <= '0;
    end else if (state_q == StLoad && cmd_valid_i && cmd_i.is_word) w_q[cmd_i.widx] <= cmd_i.word;
    else if (state_q == StRun) w_q[ri] <= wr_word;
    else if (state_q == StAdd) begin
      for (int i = 0; i < 16; i++) w_q[i] <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StLoad && cmd_valid_i && cmd_i.compress) begin
      a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
    end else if (state_q == StRun) begin
      a_q <= t; b_q <= a_q; c_q <= {b_q[1:0], b_q[31:2]}; d_q <= c_q; e_q <= d_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      r_q     <= '0;
      fin_q   <= 1'b0;
      oidx_q  <= '0;
      h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
    end else begin
      unique case (state_q)
        StLoad: begin
          if (cmd_valid_i && cmd_i.compress) begin
            state_q <= StRun;
            r_q     <= '0;
            fin_q   <= cmd_i.finish;
          end
        end
        StRun: begin
          r_q <= r_q + 7'd1;
          if (r_q == 7'd79) state_q <= StAdd;
        end
        StAdd: begin
          h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q; h_q[2] <= h_q[2] + c_q;
          h_q[3] <= h_q[3] + d_q; h_q[4] <= h_q[4] + e_q;
          oidx_q  <= '0;
          state_q <= fin_q ? StOut : StLoad;
        end
        default: begin
          if (pop_i) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == 3'd4) begin
              state_q <= StLoad;
              h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
            end
          end
        end
      endcase
    end
  end

endmodule

// ===== src/sha1_message_digest.sv =====
// sha1 message digest top level
//
//  channel | handshake    | payload
//  input   | push / full  | in_item_i  (data_byte, has_data, last_byte)
//  result  | pop / empty  | out_item_o (digest_word, word_index, last_word)
//
// one data byte per cycle into the packer while full is low; every 64th byte starts an
// 80-round compression plus an add step in the core, one round per cycle
// ending pads with zero words and the two length words plus one or two compressions,
// then gives five digest items
// the two-entry command queue lets up to eight bytes of the next block pack
// while a block compresses, then full holds the input
// reset restores the initial chaining value and clears all counts
`timescale 1ns / 1ps
module sha1_message_digest #(
  parameter int LengthBits = sha1_pkg::LengthBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  sha1_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output sha1_pkg::out_item_t out_item_o
);
  import sha1_pkg::*;

  logic f_valid, f_ready, c_valid, c_ready;
  cmd_t f_cmd, c_cmd;

  sha1_front #(.LengthBits(LengthBits)) u_front (
    .clk_i, .rst_ni, .push_i(push), .in_item_i, .full_o(full),
    .cmd_valid_o(f_valid), .cmd_o(f_cmd), .cmd_ready_i(f_ready)
  );

  sha1_cmd_fifo u_fifo (
    .clk_i, .rst_ni, .wr_valid_i(f_valid), .wr_cmd_i(f_cmd), .wr_ready_o(f_ready),
    .rd_valid_o(c_valid), .rd_cmd_o(c_cmd), .rd_ready_i(c_ready)
  );

  sha1_core u_core (
    .clk_i, .rst_ni, .cmd_valid_i(c_valid), .cmd_i(c_cmd), .cmd_ready_o(c_ready),
    .empty_o(empty), .out_item_o, .pop_i(pop)
  );

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.last_word == (out_item_o.word_index == 3'd4)))
    else $error("last_word mismatch");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> out_item_o.word_index <= 3'd4)
    else $error("word index out of range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty && $stable(out_item_o.word_index))
    else $error("result changed while waiting");

endmodule
